/* src/aesr_pkg.sv */
package aesr_pkg;

  localparam int NumRows  = 4;
  localparam int NumCols  = 4;
  localparam int NumBytes = NumRows * NumCols;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_MID   = 2'd1;
  localparam logic [1:0] CMD_FINAL = 2'd2;

  typedef logic [7:0] byte_t;
  typedef byte_t col_t [NumRows];

  // per-item lane control
  typedef struct packed {
    logic sub_shift;
    logic mix;
  } lane_ctrl_t;

  localparam byte_t SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic byte_t xtime(input byte_t v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

/* src/aesr_column_lane.sv */
module aesr_column_lane
  import aesr_pkg::*;
(
  input  lane_ctrl_t ctrl,
  input  col_t       col_in,
  input  col_t       key_in,
  output col_t       col_out
);

  col_t s;
  col_t d;
  col_t m;

  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      s[r] = ctrl.sub_shift ? SBOX[col_in[r]] : col_in[r];
      d[r] = xtime(s[r]);
    end
    m[0] = d[0] ^ d[1] ^ s[1] ^ s[2] ^ s[3];
    m[1] = s[0] ^ d[1] ^ d[2] ^ s[2] ^ s[3];
    m[2] = s[0] ^ s[1] ^ d[2] ^ d[3] ^ s[3];
    m[3] = d[0] ^ s[0] ^ s[1] ^ s[2] ^ d[3];
    for (int r = 0; r < NumRows; r++) begin
      col_out[r] = (ctrl.mix ? m[r] : s[r]) ^ key_in[r];
    end
  end

endmodule

/* src/aesr_out_buf.sv */
module aesr_out_buf
  import aesr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  logic [8*NumBytes-1:0]  din,
  output logic                   ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [8*NumBytes-1:0]  dout
);

  logic                  main_valid_r, main_valid_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  logic [8*NumBytes-1:0] main_data_r, main_data_nxt;
  logic [8*NumBytes-1:0] skid_data_r, skid_data_nxt;

  assign ready     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign dout      = main_data_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    if (!main_valid_r || out_ready) begin
      // advance: drain the skid first, else load the new item
      if (skid_valid_r) begin
        main_data_nxt  = skid_data_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_data_nxt  = din;
        main_valid_nxt = take;
      end
    end else if (take) begin
      // hold the head, park the new item
      skid_data_nxt  = din;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid holds an item while head is empty");

  a_park_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (take && main_valid_r && !out_ready) |=> (skid_valid_r && skid_data_r == $past(din)))
    else $error("item taken under stall was not parked");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> (!skid_valid_r && main_data_r == $past(skid_data_r)))
    else $error("skid item not moved to head");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !take)
    else $error("item taken with both entries full");

endmodule

/* src/aes_encrypt_round_unit.sv */
// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------------------
// input    | in_valid / in_ready  | in_command, in_state_lo/hi, in_key_lo/hi
// result   | out_valid / out_ready| out_result_lo, out_result_hi
//
// One item per cycle sustained while out_ready stays high; each result is registered at the
// output, and is held back only while an earlier result is still waiting at the output.
// The round is done by four column lanes in the input cycle and registered at the output.
// A two-entry output buffer lets an item be taken while the previous result is stalled;
// in_ready drops only when both entries are full.
// Reset (rst_n, synchronous) empties the output buffer; the round itself keeps no state.
module aes_encrypt_round_unit
  import aesr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [63:0] in_state_lo,
  input  logic [63:0] in_state_hi,
  input  logic [63:0] in_key_lo,
  input  logic [63:0] in_key_hi,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_lo,
  output logic [63:0] out_result_hi
);

  logic [8*NumBytes-1:0] st_w;
  logic [8*NumBytes-1:0] key_w;
  logic [8*NumBytes-1:0] res_w;
  logic [8*NumBytes-1:0] res_q;
  lane_ctrl_t            ctrl;
  col_t                  lane_in  [NumCols];
  col_t                  lane_key [NumCols];
  col_t                  lane_out [NumCols];
  logic                  take;

  assign st_w  = {in_state_hi, in_state_lo};
  assign key_w = {in_key_hi, in_key_lo};

  // command 3 behaves as a final round
  assign ctrl.sub_shift = (in_command != CMD_INIT);
  assign ctrl.mix       = (in_command == CMD_MID);

  // distribute: row r of column c comes from column (c + r) mod 4 when shifting
  always_comb begin
    for (int c = 0; c < NumCols; c++) begin
      for (int r = 0; r < NumRows; r++) begin
        lane_in[c][r]  = ctrl.sub_shift ? st_w[8*(r*NumCols + ((c + r) % NumCols)) +: 8]
                                        : st_w[8*(r*NumCols + c) +: 8];
        lane_key[c][r] = key_w[8*(r*NumCols + c) +: 8];
      end
    end
  end

  for (genvar c = 0; c < NumCols; c++) begin : g_lane
    aesr_column_lane u_lane (
      .ctrl    (ctrl),
      .col_in  (lane_in[c]),
      .key_in  (lane_key[c]),
      .col_out (lane_out[c])
    );
  end

  // merge lane columns back into row-major bytes
  always_comb begin
    for (int c = 0; c < NumCols; c++) begin
      for (int r = 0; r < NumRows; r++) begin
        res_w[8*(r*NumCols + c) +: 8] = lane_out[c][r];
      end
    end
  end

  assign take = in_valid && in_ready;

  aesr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .din       (res_w),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (res_q)
  );

  assign out_result_lo = res_q[63:0];
  assign out_result_hi = res_q[127:64];

endmodule

/* tb/testbench.sv */
module testbench;
  import aesr_pkg::*;

  // code 3 is not defined and decodes as a final round
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int ItemsPerPhase = 445;

  typedef struct {
    logic [1:0]  cmd;
    logic [63:0] lo;
    logic [63:0] hi;
  } round_out_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [63:0] in_state_lo;
  logic [63:0] in_state_hi;
  logic [63:0] in_key_lo;
  logic [63:0] in_key_hi;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_result_lo;
  logic [63:0] out_result_hi;

  logic [7:0]  sbox_tab [256];
  round_out_t  pending_rounds [$];
  int          mismatch_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;

  aes_encrypt_round_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_state_lo   (in_state_lo),
    .in_state_hi   (in_state_hi),
    .in_key_lo     (in_key_lo),
    .in_key_hi     (in_key_hi),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_result_lo (out_result_lo),
    .out_result_hi (out_result_hi)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("[aes_encrypt_round_unit] ERROR");
    $finish;
  end

  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Derive the S-box from the field inverse and the affine map.
  initial begin
    logic [7:0] inv;
    logic [7:0] prod;
    logic [7:0] a;
    logic [7:0] b;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++) begin
        a = x[7:0];
        b = y[7:0];
        prod = 8'h00;
        for (int i = 0; i < 8; i++) begin
          if (b[0]) prod = prod ^ a;
          a = gf_dbl(a);
          b = b >> 1;
        end
        if (prod == 8'h01) inv = y[7:0];
      end
      sbox_tab[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                    {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    end
  end

  function automatic logic [127:0] predict_round(input logic [1:0] cmd,
                                                 input logic [127:0] st_in,
                                                 input logic [127:0] rk);
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3;
    logic [127:0] res;
    for (int k = 0; k < 16; k++) s[k] = st_in[8*k +: 8];
    if (cmd != CMD_INIT) begin
      // row r takes its bytes from r columns to the right
      for (int r = 0; r < 4; r++)
        for (int c = 0; c < 4; c++)
          t[r*4 + c] = sbox_tab[s[r*4 + ((c + r) % 4)]];
      s = t;
    end
    if (cmd == CMD_MID) begin
      for (int c = 0; c < 4; c++) begin
        a0 = s[c];
        a1 = s[4 + c];
        a2 = s[8 + c];
        a3 = s[12 + c];
        s[c]      = gf_dbl(a0) ^ gf_dbl(a1) ^ a1 ^ a2 ^ a3;
        s[4 + c]  = a0 ^ gf_dbl(a1) ^ gf_dbl(a2) ^ a2 ^ a3;
        s[8 + c]  = a0 ^ a1 ^ gf_dbl(a2) ^ gf_dbl(a3) ^ a3;
        s[12 + c] = gf_dbl(a0) ^ a0 ^ a1 ^ a2 ^ gf_dbl(a3);
      end
    end
    for (int k = 0; k < 16; k++) res[8*k +: 8] = s[k] ^ rk[8*k +: 8];
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  // Record each accepted item, then compare each delivered result with the oldest one.
  always @(posedge clk) begin
    round_out_t   item;
    logic [127:0] res;
    if (rst_n && in_valid && in_ready) begin
      res = predict_round(in_command, {in_state_hi, in_state_lo}, {in_key_hi, in_key_lo});
      item.cmd = in_command;
      item.lo  = res[63:0];
      item.hi  = res[127:64];
      pending_rounds.push_back(item);
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_rounds.size() == 0) begin
        note_mismatch($sformatf("result %h_%h with no item pending",
                                out_result_hi, out_result_lo));
      end else begin
        item = pending_rounds.pop_front();
        if (out_result_lo !== item.lo)
          note_mismatch($sformatf("cmd %0d result_lo %h, want %h",
                                  item.cmd, out_result_lo, item.lo));
        if (out_result_hi !== item.hi)
          note_mismatch($sformatf("cmd %0d result_hi %h, want %h",
                                  item.cmd, out_result_hi, item.hi));
      end
    end
  end

  task automatic send_round(input logic [1:0] cmd, input logic [63:0] slo,
                            input logic [63:0] shi, input logic [63:0] klo,
                            input logic [63:0] khi);
    int gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_state_lo <= slo;
    in_state_hi <= shi;
    in_key_lo   <= klo;
    in_key_hi   <= khi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return {8{8'h80}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic run_random_rounds(input int count);
    int         r;
    logic [1:0] cmd;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 15);
      if (r == 15)         cmd = CMD_SPARE;
      else if (r % 3 == 0) cmd = CMD_INIT;
      else if (r % 3 == 1) cmd = CMD_MID;
      else                 cmd = CMD_FINAL;
      send_round(cmd, rand_word(), rand_word(), rand_word(), rand_word());
    end
  endtask

  // Every command code against all-zero, all-one, top-bit and mixed bytes.
  task automatic test_directed();
    logic [1:0]  cmds [4] = '{CMD_INIT, CMD_MID, CMD_FINAL, CMD_SPARE};
    logic [63:0] pat [5]  = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'h8080_8080_8080_8080,
                              64'h55aa_55aa_a55a_a55a, 64'h0123_4567_89ab_cdef};
    send_idle_pct = 0;
    stall_pct     = 0;
    for (int c = 0; c < 4; c++)
      for (int p = 0; p < 5; p++)
        send_round(cmds[c], pat[p], ~pat[4 - p], pat[4 - p], ~pat[p]);
  endtask

  task automatic test_streaming();
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random_rounds(ItemsPerPhase);
  endtask

  task automatic test_sender_gaps();
    send_idle_pct = 55;
    stall_pct     = 0;
    run_random_rounds(ItemsPerPhase);
  endtask

  task automatic test_receiver_stalls();
    send_idle_pct = 0;
    stall_pct     = 55;
    run_random_rounds(ItemsPerPhase);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 10;
    stall_pct     = 10;
    run_random_rounds(ItemsPerPhase);
  endtask

  initial begin
    in_valid    <= 1'b0;
    in_command  <= CMD_INIT;
    in_state_lo <= '0;
    in_state_hi <= '0;
    in_key_lo   <= '0;
    in_key_hi   <= '0;
    out_ready   <= 1'b0;
    rst_n       <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    in_valid <= 1'b0;

    // drain, bounded
    for (int w = 0; w < 2000 && pending_rounds.size() != 0; w++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_rounds.size() != 0)
      note_mismatch($sformatf("%0d results never delivered", pending_rounds.size()));

    if (mismatch_count == 0) begin
      $display("[aes_encrypt_round_unit] OK");
    end else begin
      $display("[aes_encrypt_round_unit] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/aesr_pkg.sv
src/aesr_column_lane.sv
src/aesr_out_buf.sv
src/aes_encrypt_round_unit.sv
tb/testbench.sv
